>>> rtl/crc8_frame_receiver_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the CRC-8 frame receiver
// Clocked property macros used by the top level, which carries the assertions.
// ----------------------------------------------------------------------------
`ifndef CRC8_FRAME_RECEIVER_ASSERT_SVH
`define CRC8_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication.
`define CRC8FR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define CRC8FR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/crc8fr_pkg.sv
// ----------------------------------------------------------------------------
// CRC-8 frame receiver package
// Shared types, register indexes, status codes and the CRC-8 byte update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crc8fr_pkg;

   localparam logic [7:0] CSR_HEADER_FIRST  = 8'd0;
   localparam logic [7:0] CSR_HEADER_SECOND = 8'd1;
   localparam logic [7:0] CSR_ID_MINIMUM    = 8'd2;
   localparam logic [7:0] CSR_ID_MAXIMUM    = 8'd3;

   localparam logic [7:0] RESET_HEADER_FIRST  = 8'd170;
   localparam logic [7:0] RESET_HEADER_SECOND = 8'd85;
   localparam logic [7:0] RESET_ID_MINIMUM    = 8'd0;
   localparam logic [7:0] RESET_ID_MAXIMUM    = 8'd255;

   localparam logic [1:0] STATUS_VALID     = 2'd0;
   localparam logic [1:0] STATUS_CRC_ERROR = 2'd1;
   localparam logic [1:0] STATUS_BAD_ID    = 2'd2;

   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'h8C;

   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [7:0] header_first;
      logic [7:0] header_second;
      logic [7:0] id_minimum;
      logic [7:0] id_maximum;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  frame_status;
      logic [7:0]  mode_value;
      logic [7:0]  id_value;
      logic [15:0] extra_payload;
      logic [31:0] good_frames;
      logic [31:0] crc_failures;
      logic [31:0] bad_id_frames;
   } rsp_type;

   typedef struct packed {
      logic at_crc;
      logic hunting;
   } stat_type;

   // Reflected CRC-8, one byte per call.
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

>>> rtl/crc8_frame_receiver.sv
// The receiver takes one byte per clock on the req_ stream, hunts for the two
// header bytes and then collects mode, id, EXTRA_BYTES extra bytes and a
// reflected CRC-8 byte (polynomial 0x8C, start 0xFF). When the CRC byte is
// accepted, one result appears on the rsp_ stream in the next cycle, carrying
// the status in rsp_tuser and the frame fields and counters in rsp_tdata.
// Bytes are accepted every cycle; the only stall is a CRC byte that arrives
// while the single result register still holds a result not yet taken, since
// that register is the one place a result can wait. There is no clearing
// pass after reset. Configuration writes take effect at the next clock edge.
// ----------------------------------------------------------------------------
// CRC-8 frame receiver
// Top level: configuration, parser and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "crc8_frame_receiver_assert.svh"

module crc8_frame_receiver #(
   parameter int EXTRA_BYTES = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [7:0] rx_byte
   input  logic [7:0]   req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [7:0] mode_value, [15:8] id_value, [31:16] extra_payload,
   // [63:32] good_frames, [95:64] crc_failures, [127:96] bad_id_frames
   output logic [127:0] rsp_tdata,
   // [1:0] frame_status
   output logic [1:0]   rsp_tuser,
   input  logic         csr_we,
   input  logic [7:0]   csr_index,
   input  logic [7:0]   csr_wdata
);

   crc8fr_pkg::cfg_type  cfg;
   crc8fr_pkg::stat_type stat;
   crc8fr_pkg::rsp_type  rsp_new;
   crc8fr_pkg::rsp_type  rsp_held;
   logic                 req_accept;
   logic                 rsp_load;
   logic                 slot_free;

   assign slot_free  = !rsp_tvalid || rsp_tready;
   assign req_tready = !stat.at_crc || slot_free;
   assign req_accept = req_tvalid && req_tready;

   crc8fr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   crc8fr_parser #(
      .EXTRA_BYTES (EXTRA_BYTES)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_valid (req_accept),
      .in_byte  (req_tdata),
      .stat     (stat),
      .rsp_fire (rsp_load),
      .rsp      (rsp_new)
   );

   crc8fr_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (rsp_load),
      .load_data  (rsp_new),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_data   (rsp_held)
   );

   assign rsp_tuser = rsp_held.frame_status;
   assign rsp_tdata = {rsp_held.bad_id_frames, rsp_held.crc_failures,
                       rsp_held.good_frames, rsp_held.extra_payload,
                       rsp_held.id_value, rsp_held.mode_value};

   `CRC8FR_ASSERT_IMP(a_load_into_free_slot, clock, reset, rsp_load, slot_free, "result overwritten")
   `CRC8FR_ASSERT_NEXT(a_load_shows_result, clock, reset, rsp_load, rsp_tvalid, "result not shown")
   `CRC8FR_ASSERT_NEXT(a_crc_byte_rehunts, clock, reset, req_accept && stat.at_crc, stat.hunting, "no rehunt")

endmodule

>>> rtl/crc8fr_csr.sv
// ----------------------------------------------------------------------------
// CRC-8 frame receiver configuration registers
// Holds the header values and the accepted id range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc8fr_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [7:0]          csr_index,
   input  logic [7:0]          csr_wdata,
   output crc8fr_pkg::cfg_type cfg
);

   crc8fr_pkg::cfg_type cfg_ff;
   crc8fr_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            crc8fr_pkg::CSR_HEADER_FIRST:  cfg_in.header_first  = csr_wdata;
            crc8fr_pkg::CSR_HEADER_SECOND: cfg_in.header_second = csr_wdata;
            crc8fr_pkg::CSR_ID_MINIMUM:    cfg_in.id_minimum    = csr_wdata;
            crc8fr_pkg::CSR_ID_MAXIMUM:    cfg_in.id_maximum    = csr_wdata;
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_first  <= crc8fr_pkg::RESET_HEADER_FIRST;
         cfg_ff.header_second <= crc8fr_pkg::RESET_HEADER_SECOND;
         cfg_ff.id_minimum    <= crc8fr_pkg::RESET_ID_MINIMUM;
         cfg_ff.id_maximum    <= crc8fr_pkg::RESET_ID_MAXIMUM;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/crc8fr_parser.sv
// ----------------------------------------------------------------------------
// CRC-8 frame receiver parser
// Header hunt, frame field capture, running CRC and saturating counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc8fr_parser #(
   parameter int EXTRA_BYTES = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  crc8fr_pkg::cfg_type  cfg,
   input  logic                 in_valid,
   input  logic [7:0]           in_byte,
   output crc8fr_pkg::stat_type stat,
   output logic                 rsp_fire,
   output crc8fr_pkg::rsp_type  rsp
);

   localparam int POS_W = $clog2(EXTRA_BYTES + 5);
   localparam logic [POS_W-1:0] POS_HUNT     = POS_W'(0);
   localparam logic [POS_W-1:0] POS_HEADER   = POS_W'(1);
   localparam logic [POS_W-1:0] POS_MODE     = POS_W'(2);
   localparam logic [POS_W-1:0] POS_ID       = POS_W'(3);
   localparam logic [POS_W-1:0] POS_EXTRA_LO = POS_W'(4);
   localparam logic [POS_W-1:0] POS_EXTRA_HI = POS_W'(5);
   localparam logic [POS_W-1:0] POS_CRC      = POS_W'(EXTRA_BYTES + 4);

   logic [POS_W-1:0] pos_ff,   pos_in;
   logic [7:0]       crc_ff,   crc_in;
   logic [7:0]       mode_ff,  mode_in;
   logic [7:0]       id_ff,    id_in;
   logic [15:0]      extra_ff, extra_in;
   logic [31:0]      good_ff,  good_in;
   logic [31:0]      fail_ff,  fail_in;
   logic [31:0]      bad_ff,   bad_in;
   logic [7:0]       crc_next;
   logic [7:0]       crc_restart;
   logic             crc_ok;
   logic             id_ok;
   logic [1:0]       status;

   assign crc_next    = crc8fr_pkg::crc8_update(crc_ff, in_byte);
   assign crc_restart = crc8fr_pkg::crc8_update(crc8fr_pkg::CRC_INIT, in_byte);
   assign crc_ok      = (in_byte == crc_ff);
   assign id_ok       = (id_ff >= cfg.id_minimum) && (id_ff <= cfg.id_maximum);

   always_comb begin
      pos_in   = pos_ff;
      crc_in   = crc_ff;
      mode_in  = mode_ff;
      id_in    = id_ff;
      extra_in = extra_ff;
      good_in  = good_ff;
      fail_in  = fail_ff;
      bad_in   = bad_ff;
      status   = crc8fr_pkg::STATUS_VALID;
      if (!crc_ok) begin
         status = crc8fr_pkg::STATUS_CRC_ERROR;
      end else if (!id_ok) begin
         status = crc8fr_pkg::STATUS_BAD_ID;
      end
      if (in_valid) begin
         if (pos_ff == POS_HUNT) begin
            if (in_byte == cfg.header_first) begin
               crc_in = crc_restart;
               pos_in = POS_HEADER;
            end
         end else if (pos_ff == POS_HEADER) begin
            if (in_byte == cfg.header_second) begin
               crc_in = crc_next;
               pos_in = POS_MODE;
            end else if (in_byte == cfg.header_first) begin
               crc_in = crc_restart;
            end else begin
               pos_in = POS_HUNT;
            end
         end else if (pos_ff < POS_CRC) begin
            crc_in = crc_next;
            pos_in = pos_ff + POS_W'(1);
            if (pos_ff == POS_MODE) begin
               mode_in  = in_byte;
               extra_in = '0;
            end else if (pos_ff == POS_ID) begin
               id_in = in_byte;
            end else if (pos_ff == POS_EXTRA_LO) begin
               extra_in[7:0] = in_byte;
            end else if (pos_ff == POS_EXTRA_HI) begin
               extra_in[15:8] = in_byte;
            end
         end else begin
            pos_in = POS_HUNT;
            if (!crc_ok) begin
               if (fail_ff != crc8fr_pkg::COUNT_MAX) begin
                  fail_in = fail_ff + 32'd1;
               end
            end else if (!id_ok) begin
               if (bad_ff != crc8fr_pkg::COUNT_MAX) begin
                  bad_in = bad_ff + 32'd1;
               end
            end else if (good_ff != crc8fr_pkg::COUNT_MAX) begin
               good_in = good_ff + 32'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= POS_HUNT;
         crc_ff   <= crc8fr_pkg::CRC_INIT;
         mode_ff  <= '0;
         id_ff    <= '0;
         extra_ff <= '0;
         good_ff  <= '0;
         fail_ff  <= '0;
         bad_ff   <= '0;
      end else begin
         pos_ff   <= pos_in;
         crc_ff   <= crc_in;
         mode_ff  <= mode_in;
         id_ff    <= id_in;
         extra_ff <= extra_in;
         good_ff  <= good_in;
         fail_ff  <= fail_in;
         bad_ff   <= bad_in;
      end
   end

   assign stat.at_crc  = (pos_ff == POS_CRC);
   assign stat.hunting = (pos_ff == POS_HUNT);
   assign rsp_fire     = in_valid && (pos_ff == POS_CRC);

   assign rsp.frame_status  = status;
   assign rsp.mode_value    = mode_ff;
   assign rsp.id_value      = id_ff;
   assign rsp.extra_payload = extra_ff;
   assign rsp.good_frames   = good_in;
   assign rsp.crc_failures  = fail_in;
   assign rsp.bad_id_frames = bad_in;

endmodule

>>> rtl/crc8fr_out_reg.sv
// ----------------------------------------------------------------------------
// CRC-8 frame receiver result register
// Holds one finished result until the downstream side takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc8fr_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  crc8fr_pkg::rsp_type load_data,
   input  logic                rsp_tready,
   output logic                rsp_tvalid,
   output crc8fr_pkg::rsp_type rsp_data
);

   logic                valid_ff, valid_in;
   crc8fr_pkg::rsp_type data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_data   = data_ff;

endmodule

>>> tb/crc8_frame_receiver_tb.sv
// ----------------------------------------------------------------------------
// CRC-8 frame receiver testbench
// Sends framed and unframed bytes with random gaps, stalls the result stream
// on its own pattern, predicts every frame result from a behavioural copy of
// the parser and checks each result field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc8_frame_receiver_tb;
   import crc8fr_pkg::*;

   localparam int EXTRA_BYTES = 2;
   localparam int CRC_STAGE = 4 + EXTRA_BYTES;
   localparam int RANDOM_BYTES = 1900;
   localparam int RANDOM_PHASES = 6;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_REPORTS = 100;
   localparam logic [7:0] CSR_NO_REG = 8'd4;
   localparam logic [7:0] CSR_TOP_INDEX = 8'hFF;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = 8'h00;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_we = 1'b0;
   logic [7:0]   csr_index = 8'h00;
   logic [7:0]   csr_wdata = 8'h00;

   // Parser copy and its configuration.
   logic [3:0]  rx_stage;
   logic [7:0]  crc_acc;
   logic [7:0]  mode_seen;
   logic [7:0]  id_seen;
   logic [15:0] extra_seen;
   logic [31:0] good_total;
   logic [31:0] crc_fail_total;
   logic [31:0] bad_id_total;
   logic [7:0]  hdr_a;
   logic [7:0]  hdr_b;
   logic [7:0]  id_lo;
   logic [7:0]  id_hi;

   rsp_type frame_results_due [$];

   logic [31:0] cycle_count = 0;
   int mismatches = 0;
   int results_checked = 0;
   int bytes_sent = 0;
   int noise_bytes = 0;
   int frames_sent = 0;
   int regs_written = 0;
   int burst_left = 0;
   bit req_hot = 1'b0;

   crc8_frame_receiver #(
      .EXTRA_BYTES(EXTRA_BYTES)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped at the cycle limit with %0d results outstanding",
                  frame_results_due.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // The result side is ready always, half the time, rarely, or on a fixed
   // rhythm, switching mode with bits [9:8] of the cycle counter.
   always @(posedge clock) begin
      case (cycle_count[9:8])
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= $urandom_range(0, 1) == 1;
         2'd2: rsp_tready <= $urandom_range(0, 3) == 0;
         default: rsp_tready <= cycle_count[2:0] != 3'd2 && cycle_count[2:0] != 3'd5;
      endcase
   end

   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] r;
      logic fb;
      r = crc;
      for (int i = 0; i < 8; i++) begin
         fb = r[0] ^ data[i];
         r = r >> 1;
         if (fb) begin
            r = r ^ CRC_POLY;
         end
      end
      return r;
   endfunction

   function automatic logic [31:0] count_up(input logic [31:0] v);
      return (v == COUNT_MAX) ? v : v + 32'd1;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatches < MAX_REPORTS) begin
         $display("[%0t] %s", $time, msg);
      end
      mismatches++;
   endtask

   task automatic predict_rx_byte(input logic [7:0] b);
      rsp_type res;
      int off;
      off = int'(rx_stage) - 4;
      if (rx_stage == 4'd0) begin
         if (b == hdr_a) begin
            crc_acc = crc8_step(CRC_INIT, b);
            rx_stage = 4'd1;
         end
      end else if (rx_stage == 4'd1) begin
         if (b == hdr_b) begin
            crc_acc = crc8_step(crc_acc, b);
            rx_stage = 4'd2;
         end else if (b == hdr_a) begin
            crc_acc = crc8_step(CRC_INIT, b);
         end else begin
            rx_stage = 4'd0;
         end
      end else if (int'(rx_stage) < CRC_STAGE) begin
         crc_acc = crc8_step(crc_acc, b);
         if (rx_stage == 4'd2) begin
            mode_seen = b;
            extra_seen = '0;
         end else if (rx_stage == 4'd3) begin
            id_seen = b;
         end else if (off < 2) begin
            extra_seen[8*off +: 8] = b;
         end
         rx_stage = rx_stage + 4'd1;
      end else begin
         if (b != crc_acc) begin
            crc_fail_total = count_up(crc_fail_total);
            res.frame_status = STATUS_CRC_ERROR;
         end else if (id_seen < id_lo || id_seen > id_hi) begin
            bad_id_total = count_up(bad_id_total);
            res.frame_status = STATUS_BAD_ID;
         end else begin
            good_total = count_up(good_total);
            res.frame_status = STATUS_VALID;
         end
         res.mode_value = mode_seen;
         res.id_value = id_seen;
         res.extra_payload = (EXTRA_BYTES > 0) ? extra_seen : 16'h0000;
         res.good_frames = good_total;
         res.crc_failures = crc_fail_total;
         res.bad_id_frames = bad_id_total;
         frame_results_due.push_back(res);
         rx_stage = 4'd0;
      end
   endtask

   task automatic check_frame_result();
      rsp_type due;
      if (frame_results_due.size() == 0) begin
         report_mismatch($sformatf("result with no frame pending: tuser %0d tdata %h",
                                   rsp_tuser, rsp_tdata));
         return;
      end
      due = frame_results_due.pop_front();
      if (rsp_tuser !== due.frame_status) begin
         report_mismatch($sformatf("result %0d: frame_status %0d, expected %0d",
                                   results_checked, rsp_tuser, due.frame_status));
      end
      if (rsp_tdata[7:0] !== due.mode_value) begin
         report_mismatch($sformatf("result %0d: mode_value %h, expected %h",
                                   results_checked, rsp_tdata[7:0], due.mode_value));
      end
      if (rsp_tdata[15:8] !== due.id_value) begin
         report_mismatch($sformatf("result %0d: id_value %h, expected %h",
                                   results_checked, rsp_tdata[15:8], due.id_value));
      end
      if (rsp_tdata[31:16] !== due.extra_payload) begin
         report_mismatch($sformatf("result %0d: extra_payload %h, expected %h",
                                   results_checked, rsp_tdata[31:16], due.extra_payload));
      end
      if (rsp_tdata[63:32] !== due.good_frames) begin
         report_mismatch($sformatf("result %0d: good_frames %0d, expected %0d",
                                   results_checked, rsp_tdata[63:32], due.good_frames));
      end
      if (rsp_tdata[95:64] !== due.crc_failures) begin
         report_mismatch($sformatf("result %0d: crc_failures %0d, expected %0d",
                                   results_checked, rsp_tdata[95:64], due.crc_failures));
      end
      if (rsp_tdata[127:96] !== due.bad_id_frames) begin
         report_mismatch($sformatf("result %0d: bad_id_frames %0d, expected %0d",
                                   results_checked, rsp_tdata[127:96], due.bad_id_frames));
      end
      results_checked++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rx_stage = 4'd0;
         crc_acc = CRC_INIT;
         mode_seen = 8'h00;
         id_seen = 8'h00;
         extra_seen = 16'h0000;
         good_total = 32'd0;
         crc_fail_total = 32'd0;
         bad_id_total = 32'd0;
         hdr_a = RESET_HEADER_FIRST;
         hdr_b = RESET_HEADER_SECOND;
         id_lo = RESET_ID_MINIMUM;
         id_hi = RESET_ID_MAXIMUM;
         frame_results_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_frame_result();
         end
         if (csr_we) begin
            case (csr_index)
               CSR_HEADER_FIRST:  hdr_a = csr_wdata;
               CSR_HEADER_SECOND: hdr_b = csr_wdata;
               CSR_ID_MINIMUM:    id_lo = csr_wdata;
               CSR_ID_MAXIMUM:    id_hi = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            predict_rx_byte(req_tdata);
         end
      end
   end

   // Bytes go out in bursts of random length separated by random gaps.
   task automatic send_byte(input logic [7:0] b);
      if (burst_left == 0) begin
         if (req_hot) begin
            req_tvalid <= 1'b0;
         end
         req_hot = 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 16);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_hot = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic release_req();
      if (req_hot) begin
         req_tvalid <= 1'b0;
      end
      req_hot = 1'b0;
      burst_left = 0;
   endtask

   task automatic send_frame(input logic [7:0] mode, input logic [7:0] id,
                             input logic [15:0] extra, input bit corrupt);
      logic [7:0] frame_bytes [$];
      logic [7:0] crc;
      frame_bytes.push_back(hdr_a);
      frame_bytes.push_back(hdr_b);
      frame_bytes.push_back(mode);
      frame_bytes.push_back(id);
      for (int i = 0; i < EXTRA_BYTES; i++) begin
         if (i < 2) begin
            frame_bytes.push_back(extra[8*i +: 8]);
         end else begin
            frame_bytes.push_back(8'($urandom));
         end
      end
      crc = CRC_INIT;
      foreach (frame_bytes[k]) begin
         crc = crc8_step(crc, frame_bytes[k]);
      end
      if (corrupt) begin
         crc = crc ^ 8'($urandom_range(1, 255));
      end
      frame_bytes.push_back(crc);
      foreach (frame_bytes[k]) begin
         send_byte(frame_bytes[k]);
      end
      frames_sent++;
   endtask

   task automatic wait_idle();
      release_req();
      @(posedge clock);
      while (frame_results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      regs_written++;
   endtask

   task automatic close_reg_writes();
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [7:0] first, input logic [7:0] second,
                             input logic [7:0] lo, input logic [7:0] hi);
      wait_idle();
      write_reg(CSR_HEADER_FIRST, first);
      write_reg(CSR_HEADER_SECOND, second);
      write_reg(CSR_ID_MINIMUM, lo);
      write_reg(CSR_ID_MAXIMUM, hi);
      close_reg_writes();
   endtask

   function automatic logic [7:0] pick_id();
      case ($urandom_range(0, 5))
         0: return id_lo;
         1: return id_hi;
         2: return id_lo - 8'd1;
         3: return id_hi + 8'd1;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic test_default_frames();
      send_frame(8'h00, 8'h00, 16'h0000, 1'b0);
      send_frame(8'hFF, 8'hFF, 16'hFFFF, 1'b0);
   endtask

   task automatic test_checksum_error();
      send_frame(8'h5A, 8'h3C, 16'h1234, 1'b1);
   endtask

   task automatic test_id_window();
      set_config(RESET_HEADER_FIRST, RESET_HEADER_SECOND, 8'd10, 8'd20);
      send_frame(8'h11, 8'd10, 16'hA5A5, 1'b0);
      send_frame(8'h22, 8'd20, 16'h5A5A, 1'b0);
      send_frame(8'h33, 8'd9, 16'h0F0F, 1'b0);
      send_frame(8'h44, 8'd21, 16'hF0F0, 1'b0);
      // Out-of-range id with a broken checksum reports the checksum.
      send_frame(8'h55, 8'd9, 16'h00FF, 1'b1);
   endtask

   task automatic test_header_hunt();
      send_byte(hdr_a);
      send_frame(8'h66, 8'd15, 16'h1111, 1'b0);
      send_byte(hdr_a);
      send_byte(8'h00);
      send_frame(8'h77, 8'd15, 16'h2222, 1'b0);
      // Equal header bytes: the second one completes the header.
      set_config(8'hFF, 8'hFF, RESET_ID_MINIMUM, RESET_ID_MAXIMUM);
      send_frame(8'h88, 8'h80, 16'h3333, 1'b0);
      set_config(8'h00, 8'h00, RESET_ID_MINIMUM, RESET_ID_MAXIMUM);
      send_frame(8'h99, 8'h01, 16'h4444, 1'b0);
   endtask

   task automatic test_inverted_window();
      set_config(RESET_HEADER_FIRST, RESET_HEADER_SECOND, 8'd200, 8'd100);
      send_frame(8'hAB, 8'd150, 16'h5555, 1'b0);
      send_frame(8'hCD, 8'd0, 16'h6666, 1'b0);
      send_frame(8'hEF, 8'd255, 16'h7777, 1'b1);
   endtask

   task automatic test_unknown_register();
      wait_idle();
      write_reg(CSR_NO_REG, 8'h00);
      write_reg(CSR_TOP_INDEX, 8'h11);
      close_reg_writes();
      send_frame(8'h12, 8'd150, 16'h8888, 1'b0);
   endtask

   task automatic test_random_traffic();
      int traffic_start;
      int pick;
      logic [7:0] other;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: set_config(RESET_HEADER_FIRST, RESET_HEADER_SECOND,
                          RESET_ID_MINIMUM, RESET_ID_MAXIMUM);
            1: set_config(8'h00, 8'hFF, 8'h00, 8'h00);
            2: set_config(8'hFF, 8'h00, 8'hFF, 8'hFF);
            3: set_config(8'h7E, 8'h7E, 8'h40, 8'hC0);
            4: set_config(8'h3C, 8'hC3, 8'h80, 8'h7F);
            default: begin
               set_config(8'($urandom), 8'($urandom), 8'($urandom_range(0, 100)),
                          8'($urandom_range(120, 255)));
               write_reg(8'($urandom_range(4, 255)), 8'($urandom));
               close_reg_writes();
            end
         endcase
         traffic_start = bytes_sent - noise_bytes;
         while (bytes_sent - noise_bytes - traffic_start < RANDOM_BYTES / RANDOM_PHASES) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               send_frame(8'($urandom), pick_id(), 16'($urandom), $urandom_range(0, 4) == 0);
            end else if (pick < 80) begin
               repeat ($urandom_range(1, 4)) begin
                  send_byte(8'($urandom));
                  noise_bytes++;
               end
            end else if (pick < 90) begin
               repeat ($urandom_range(1, 3)) send_byte(hdr_a);
               send_frame(8'($urandom), pick_id(), 16'($urandom), $urandom_range(0, 4) == 0);
            end else begin
               do begin
                  other = 8'($urandom);
               end while (other == hdr_a || other == hdr_b);
               send_byte(hdr_a);
               send_byte(other);
            end
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_default_frames();
      test_checksum_error();
      test_id_window();
      test_header_hunt();
      test_inverted_window();
      test_unknown_register();
      test_random_traffic();
      wait_idle();
      $display("Sent %0d bytes: %0d frames, %0d noise bytes, %0d register writes",
               bytes_sent, frames_sent, noise_bytes, regs_written);
      $display("Checked %0d results: %0d valid, %0d checksum errors, %0d bad ids, %0d mismatches",
               results_checked, good_total, crc_fail_total, bad_id_total, mismatches);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
